// ===== rtl/llsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llsd_pkg
// Shared types and constants for the least-loaded storage dispatcher.
// ----------------------------------------------------------------------------
package llsd_pkg;

  // Fixed field widths of the channels
  localparam int FUNC_BITS      = 1;
  localparam int UNIT_BITS      = 3;
  localparam int SECTOR_BITS    = 32;
  localparam int VALUE_BITS     = 16;
  localparam int LOAD_BITS      = 21;
  localparam int WEIGHT_BITS    = 4;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [LOAD_BITS-1:0] LOAD_MAX = '1;

  // Item function codes
  localparam logic [FUNC_BITS-1:0] FUNC_ASSIGN = 1'b0;
  localparam logic [FUNC_BITS-1:0] FUNC_SET    = 1'b1;

  // Register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_JOB_WEIGHT      = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RESPONSE_WEIGHT = 2'd1;

  localparam logic [WEIGHT_BITS-1:0] JOB_WEIGHT_RST      = 4'd2;
  localparam logic [WEIGHT_BITS-1:0] RESPONSE_WEIGHT_RST = 4'd1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  // Sequencer to unit store
  typedef struct packed {
    logic rd_en;
    logic jobs_we;
    logic resp_we;
  } store_ctl_t;

endpackage

// ===== rtl/least_loaded_storage_dispatch.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// least_loaded_storage_dispatch
// Weighted least-loaded job dispatcher over a fixed set of storage units.
// ----------------------------------------------------------------------------
// An assign word scans the units one per cycle through a single multiply-add
// unit (load = job_weight * jobs + response_weight * responses) and a running
// minimum; ties go to the lowest index. The scan is pipelined behind the
// counter memory's registered read. The input is stalled through the scan and
// finish of an assign word and through the finish of a set word. The result
// sits in an output register, so the next word is taken while it waits; a new
// result is only produced once that register drains. The user writes weights
// on the cfg port while the block is idle; the block does not enforce this.
// cfg_ready is always high. After reset no unit is connected and no clearing
// pass is needed.
// ----------------------------------------------------------------------------
module least_loaded_storage_dispatch import llsd_pkg::*; #(
  parameter int NUM_UNITS  = 8,
  parameter int COUNT_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [FUNC_BITS-1:0]      in_func,
  input  logic [UNIT_BITS-1:0]      in_unit_index,
  input  logic [SECTOR_BITS-1:0]    in_job_sector,
  input  logic [VALUE_BITS-1:0]     in_jobs_value,
  input  logic [VALUE_BITS-1:0]     in_responses_value,
  input  logic                      in_connected_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_found,
  output logic [UNIT_BITS-1:0]      out_chosen_unit,
  output logic [LOAD_BITS-1:0]      out_chosen_load,
  output logic [SECTOR_BITS-1:0]    out_assigned_sector,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [WEIGHT_BITS-1:0]    cfg_data
);

  localparam int UW = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
  localparam int LW = COUNT_BITS + 5;

  logic [WEIGHT_BITS-1:0] job_weight_r;
  logic [WEIGHT_BITS-1:0] response_weight_r;
  store_ctl_t             st_ctl;
  logic [UW-1:0]          st_addr;
  logic [COUNT_BITS-1:0]  st_jobs;
  logic [COUNT_BITS-1:0]  st_resp;
  logic                   st_conn;
  logic [COUNT_BITS-1:0]  rd_jobs;
  logic [COUNT_BITS-1:0]  rd_resp;
  logic                   rd_conn;
  logic                   rd_v;
  logic [UW-1:0]          rd_idx;
  logic                   ld_v;
  logic [UW-1:0]          ld_idx;
  logic [LW-1:0]          ld_load;
  logic [COUNT_BITS-1:0]  ld_jobs;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_weight_r      <= JOB_WEIGHT_RST;
      response_weight_r <= RESPONSE_WEIGHT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_JOB_WEIGHT:      job_weight_r      <= cfg_data;
        REG_RESPONSE_WEIGHT: response_weight_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  llsd_seq #(
    .NUM_UNITS  (NUM_UNITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_seq (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_func             (in_func),
    .in_unit_index       (in_unit_index),
    .in_job_sector       (in_job_sector),
    .in_jobs_value       (in_jobs_value),
    .in_responses_value  (in_responses_value),
    .in_connected_value  (in_connected_value),
    .st_ctl              (st_ctl),
    .st_addr             (st_addr),
    .st_jobs             (st_jobs),
    .st_resp             (st_resp),
    .st_conn             (st_conn),
    .rd_v                (rd_v),
    .rd_idx              (rd_idx),
    .ld_v                (ld_v),
    .ld_idx              (ld_idx),
    .ld_load             (ld_load),
    .ld_jobs             (ld_jobs),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_found           (out_found),
    .out_chosen_unit     (out_chosen_unit),
    .out_chosen_load     (out_chosen_load),
    .out_assigned_sector (out_assigned_sector)
  );

  llsd_store #(
    .NUM_UNITS  (NUM_UNITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (st_ctl),
    .addr    (st_addr),
    .wr_jobs (st_jobs),
    .wr_resp (st_resp),
    .wr_conn (st_conn),
    .rd_jobs (rd_jobs),
    .rd_resp (rd_resp),
    .rd_conn (rd_conn)
  );

  llsd_load_unit #(
    .NUM_UNITS  (NUM_UNITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_load (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_weight      (job_weight_r),
    .response_weight (response_weight_r),
    .in_v            (rd_v),
    .in_idx          (rd_idx),
    .jobs            (rd_jobs),
    .resp            (rd_resp),
    .conn            (rd_conn),
    .ld_v            (ld_v),
    .ld_idx          (ld_idx),
    .ld_load         (ld_load),
    .ld_jobs         (ld_jobs)
  );

endmodule

// ===== rtl/llsd_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llsd_store
// Per-unit job and response counters in memory, connected flags in flops.
// ----------------------------------------------------------------------------
module llsd_store import llsd_pkg::*; #(
  parameter int NUM_UNITS  = 8,
  parameter int COUNT_BITS = 16,
  localparam int UW = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  store_ctl_t            ctl,
  input  logic [UW-1:0]         addr,
  input  logic [COUNT_BITS-1:0] wr_jobs,
  input  logic [COUNT_BITS-1:0] wr_resp,
  input  logic                  wr_conn,
  output logic [COUNT_BITS-1:0] rd_jobs,
  output logic [COUNT_BITS-1:0] rd_resp,
  output logic                  rd_conn
);

  logic [COUNT_BITS-1:0] jobs_mem [NUM_UNITS];
  logic [COUNT_BITS-1:0] resp_mem [NUM_UNITS];
  logic [NUM_UNITS-1:0]  conn_r;
  logic [COUNT_BITS-1:0] rd_jobs_r;
  logic [COUNT_BITS-1:0] rd_resp_r;
  logic                  rd_conn_r;

  // Counters only matter once a set word has marked the unit connected
  always_ff @(posedge clk) begin
    if (ctl.jobs_we) begin
      jobs_mem[addr] <= wr_jobs;
    end
    if (ctl.resp_we) begin
      resp_mem[addr] <= wr_resp;
    end
    if (ctl.rd_en) begin
      rd_jobs_r <= jobs_mem[addr];
      rd_resp_r <= resp_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conn_r    <= '0;
      rd_conn_r <= 1'b0;
    end else begin
      if (ctl.resp_we) begin
        conn_r[addr] <= wr_conn;
      end
      if (ctl.rd_en) begin
        rd_conn_r <= conn_r[addr];
      end
    end
  end

  assign rd_jobs = rd_jobs_r;
  assign rd_resp = rd_resp_r;
  assign rd_conn = rd_conn_r;

endmodule

// ===== rtl/llsd_load_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llsd_load_unit
// Shared weighted-load multiply-add; one unit per cycle, registered result.
// ----------------------------------------------------------------------------
module llsd_load_unit import llsd_pkg::*; #(
  parameter int NUM_UNITS  = 8,
  parameter int COUNT_BITS = 16,
  localparam int UW = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1,
  localparam int LW = COUNT_BITS + 5
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [WEIGHT_BITS-1:0] job_weight,
  input  logic [WEIGHT_BITS-1:0] response_weight,
  input  logic                   in_v,
  input  logic [UW-1:0]          in_idx,
  input  logic [COUNT_BITS-1:0]  jobs,
  input  logic [COUNT_BITS-1:0]  resp,
  input  logic                   conn,
  output logic                   ld_v,
  output logic [UW-1:0]          ld_idx,
  output logic [LW-1:0]          ld_load,
  output logic [COUNT_BITS-1:0]  ld_jobs
);

  localparam int PW = COUNT_BITS + 4;

  logic [PW-1:0]         prod_jobs;
  logic [PW-1:0]         prod_resp;
  logic [LW-1:0]         load;
  logic                  ld_v_r;
  logic [UW-1:0]         ld_idx_r;
  logic [LW-1:0]         ld_load_r;
  logic [COUNT_BITS-1:0] ld_jobs_r;

  assign prod_jobs = PW'(job_weight) * PW'(jobs);
  assign prod_resp = PW'(response_weight) * PW'(resp);
  assign load      = LW'(prod_jobs) + LW'(prod_resp);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld_v_r <= 1'b0;
    end else begin
      // drop units that are not connected
      ld_v_r <= in_v & conn;
    end
  end

  always_ff @(posedge clk) begin
    ld_idx_r  <= in_idx;
    ld_load_r <= load;
    ld_jobs_r <= jobs;
  end

  assign ld_v    = ld_v_r;
  assign ld_idx  = ld_idx_r;
  assign ld_load = ld_load_r;
  assign ld_jobs = ld_jobs_r;

endmodule

// ===== rtl/llsd_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llsd_seq
// Sequencer: accepts words, scans the units, tracks the minimum, emits result.
// ----------------------------------------------------------------------------
module llsd_seq import llsd_pkg::*; #(
  parameter int NUM_UNITS  = 8,
  parameter int COUNT_BITS = 16,
  localparam int UW = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1,
  localparam int CW = $clog2(NUM_UNITS + 2),
  localparam int LW = COUNT_BITS + 5
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [FUNC_BITS-1:0]   in_func,
  input  logic [UNIT_BITS-1:0]   in_unit_index,
  input  logic [SECTOR_BITS-1:0] in_job_sector,
  input  logic [VALUE_BITS-1:0]  in_jobs_value,
  input  logic [VALUE_BITS-1:0]  in_responses_value,
  input  logic                   in_connected_value,
  output store_ctl_t             st_ctl,
  output logic [UW-1:0]          st_addr,
  output logic [COUNT_BITS-1:0]  st_jobs,
  output logic [COUNT_BITS-1:0]  st_resp,
  output logic                   st_conn,
  output logic                   rd_v,
  output logic [UW-1:0]          rd_idx,
  input  logic                   ld_v,
  input  logic [UW-1:0]          ld_idx,
  input  logic [LW-1:0]          ld_load,
  input  logic [COUNT_BITS-1:0]  ld_jobs,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_found,
  output logic [UNIT_BITS-1:0]   out_chosen_unit,
  output logic [LOAD_BITS-1:0]   out_chosen_load,
  output logic [SECTOR_BITS-1:0] out_assigned_sector
);

  localparam int SW = (LW > LOAD_BITS) ? LW : LOAD_BITS;

  state_t                 state_r, state_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic                   is_set_r, is_set_nxt;
  logic [SECTOR_BITS-1:0] sector_r, sector_nxt;
  logic                   rd_v_r;
  logic [UW-1:0]          rd_idx_r;
  logic                   have_r;
  logic [UW-1:0]          best_idx_r;
  logic [LW-1:0]          best_load_r;
  logic [COUNT_BITS-1:0]  best_jobs_r;
  logic                   better;
  logic                   set_ok;
  logic                   can_load;
  logic                   out_load;
  logic                   found;
  logic [LOAD_BITS-1:0]   sat_load;
  logic [COUNT_BITS-1:0]  inc_jobs;
  logic                   out_valid_r;
  logic                   out_found_r;
  logic [UNIT_BITS-1:0]   out_unit_r;
  logic [LOAD_BITS-1:0]   out_load_r;
  logic [SECTOR_BITS-1:0] out_sector_r;

  assign set_ok   = 32'(in_unit_index) < 32'(NUM_UNITS);
  assign can_load = !out_valid_r || !out_stall;
  assign better   = ld_v && (!have_r || (ld_load < best_load_r));
  assign found    = have_r && !is_set_r;
  assign inc_jobs = (&best_jobs_r) ? best_jobs_r : best_jobs_r + COUNT_BITS'(1);
  assign sat_load = (SW'(best_load_r) > SW'(LOAD_MAX)) ? LOAD_MAX
                                                       : LOAD_BITS'(best_load_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    is_set_nxt = is_set_r;
    sector_nxt = sector_r;
    st_ctl     = '0;
    st_addr    = cnt_r[UW-1:0];
    st_jobs    = COUNT_BITS'(in_jobs_value);
    st_resp    = COUNT_BITS'(in_responses_value);
    st_conn    = in_connected_value;
    in_stall   = 1'b1;
    out_load   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        st_addr  = UW'(in_unit_index);
        if (in_valid) begin
          sector_nxt = in_job_sector;
          cnt_nxt    = '0;
          if (in_func == FUNC_SET) begin
            // counters are written right at accept
            is_set_nxt     = 1'b1;
            st_ctl.jobs_we = set_ok;
            st_ctl.resp_we = set_ok;
            state_nxt      = S_FINISH;
          end else begin
            is_set_nxt = 1'b0;
            state_nxt  = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        st_ctl.rd_en = cnt_r < CW'(NUM_UNITS);
        cnt_nxt      = cnt_r + CW'(1);
        // last compare waits for the last read to pass the store and load registers
        if (cnt_r == CW'(NUM_UNITS + 1)) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        st_addr = best_idx_r;
        st_jobs = inc_jobs;
        if (can_load) begin
          out_load       = 1'b1;
          st_ctl.jobs_we = found;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      is_set_r    <= 1'b0;
      rd_v_r      <= 1'b0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      is_set_r <= is_set_nxt;
      rd_v_r   <= st_ctl.rd_en;
      if (state_r == S_IDLE) begin
        have_r <= 1'b0;
      end else if (better) begin
        have_r <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    sector_r <= sector_nxt;
    rd_idx_r <= st_addr;
    if (better) begin
      best_idx_r  <= ld_idx;
      best_load_r <= ld_load;
      best_jobs_r <= ld_jobs;
    end
    if (out_load) begin
      out_found_r  <= found;
      out_unit_r   <= found ? UNIT_BITS'(best_idx_r) : '0;
      out_load_r   <= found ? sat_load : '0;
      out_sector_r <= is_set_r ? '0 : sector_r;
    end
  end

  assign rd_v                = rd_v_r;
  assign rd_idx              = rd_idx_r;
  assign out_valid           = out_valid_r;
  assign out_found           = out_found_r;
  assign out_chosen_unit     = out_unit_r;
  assign out_chosen_load     = out_load_r;
  assign out_assigned_sector = out_sector_r;

`ifndef NO_ASSERTIONS
  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (state_r == S_FINISH))
    else $error("result loaded outside finish");

  a_inc_only_when_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && st_ctl.jobs_we) |-> (have_r && !is_set_r))
    else $error("job count bumped without a chosen unit");

  a_read_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    st_ctl.rd_en |-> (state_r == S_SCAN && !st_ctl.jobs_we && !st_ctl.resp_we))
    else $error("store read outside scan or with a write");

  a_no_compare_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !ld_v)
    else $error("load result arrived while idle");
`endif

endmodule
